/* hw/rtl/bsl_pkg.sv */
// Package for the styled Bresenham line rasterizer.
// Coordinate and error widths, style and action codes, the setup record type.
// No dependencies.
`default_nettype none

package bsl_pkg;

  localparam int COORD_BITS = 11;
  localparam int ERR_BITS   = COORD_BITS + 2;
  localparam int REM_BITS   = COORD_BITS + 1;
  localparam int PAT_BITS   = 4;

  typedef logic [COORD_BITS-1:0]      coord_t;
  typedef logic signed [ERR_BITS-1:0] err_t;
  typedef logic [REM_BITS-1:0]        rem_t;
  typedef logic [PAT_BITS-1:0]        pat_t;
  typedef logic [1:0]                 style_t;

  localparam style_t STYLE_SIMPLE = 2'd0;
  localparam style_t STYLE_DOTTED = 2'd1;
  localparam style_t STYLE_DASHED = 2'd2;

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_STEP  = 1'b1;

  // pattern index wraps after this value (step index mod 10)
  localparam pat_t PAT_MAX     = 4'd9;
  localparam pat_t DASH_ON_LEN = 4'd5;
  localparam pat_t DOT_A       = 4'd0;
  localparam pat_t DOT_B       = 4'd5;

  typedef struct packed {
    coord_t cur_x;
    coord_t cur_y;
    coord_t major_delta;
    coord_t minor_delta;
    err_t   error_term;
    rem_t   remaining;
    logic   dir_x_neg;
    logic   dir_y_neg;
    logic   steep;
  } line_setup_t;

endpackage

`default_nettype wire

/* hw/rtl/bsl_if.sv */
// Valid/ready channel interfaces of the line rasterizer: line items in,
// pixel items out, style register writes. Depends on bsl_pkg.
`default_nettype none

interface bsl_in_if import bsl_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   action;
  coord_t start_x;
  coord_t start_y;
  coord_t end_x;
  coord_t end_y;

  modport source (output valid, action, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, action, start_x, start_y, end_x, end_y, output ready);
endinterface

interface bsl_out_if import bsl_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t pixel_x;
  coord_t pixel_y;
  logic   plot;
  logic   last;

  modport source (output valid, pixel_x, pixel_y, plot, last, input ready);
  modport sink   (input valid, pixel_x, pixel_y, plot, last, output ready);
endinterface

interface bsl_cfg_if import bsl_pkg::*; ();
  logic   valid;
  logic   ready;
  style_t data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/bsl_setup.sv */
// Line setup: deltas, step directions, steep flag, error seed and position
// count for a new line. Pure combinational. Depends on bsl_pkg.
`default_nettype none

module bsl_setup import bsl_pkg::*; (
  input  coord_t      x1,
  input  coord_t      y1,
  input  coord_t      x2,
  input  coord_t      y2,
  input  style_t      style,
  output line_setup_t setup
);

  coord_t dx;
  coord_t dy;
  coord_t major;
  coord_t minor;
  logic   x_neg;
  logic   y_neg;
  logic   steep;
  logic   simple;

  always_comb begin
    x_neg  = x2 < x1;
    y_neg  = y2 < y1;
    dx     = x_neg ? x1 - x2 : x2 - x1;
    dy     = y_neg ? y1 - y2 : y2 - y1;
    steep  = dy > dx;
    major  = steep ? dy : dx;
    minor  = steep ? dx : dy;
    simple = (style != STYLE_DOTTED) && (style != STYLE_DASHED);

    setup.cur_x       = x1;
    setup.cur_y       = y1;
    setup.major_delta = major;
    setup.minor_delta = minor;
    setup.error_term  = signed'({1'b0, minor, 1'b0}) - signed'({2'b00, major});
    setup.remaining   = {1'b0, major} + {{(REM_BITS-1){1'b0}}, simple};
    setup.dir_x_neg   = x_neg;
    setup.dir_y_neg   = y_neg;
    setup.steep       = steep;
  end

endmodule

`default_nettype wire

/* hw/rtl/bresenham_styled_line_rasterizer.sv */
// Styled Bresenham line rasterizer. A start item (action 0) loads two endpoints
// and gives no pixel item; each step item (action 1) gives the next position of
// the line with plot and last flags, or nothing once the line is done. Style is
// 0 simple (every position, both endpoints), 1 dotted (every fifth), 2 dashed
// (five on, five off); 3 acts as simple. Style is to be written through cfg
// while no item is in flight; the block does not enforce this. One item is
// taken per clock while line_in.ready is high: an input register holds the
// item, the setup or one Bresenham step (an add and a compare on the error term)
// runs between it and the state and pixel registers, so a step item passes the
// input register, then the pixel register. line_in.ready drops only while pixel_out
// is stalled and both registers are full. Depends on bsl_pkg, bsl_if and bsl_setup.
`default_nettype none

module bresenham_styled_line_rasterizer import bsl_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  bsl_in_if.sink    line_in,
  bsl_out_if.source pixel_out,
  bsl_cfg_if.sink   cfg
);

  // style register
  style_t line_style;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_style <= STYLE_SIMPLE;
    end else if (cfg.valid && cfg.ready) begin
      line_style <= cfg.data;
    end
  end

  // input register
  logic   s1_valid;
  logic   s1_action;
  coord_t s1_x1, s1_y1, s1_x2, s1_y2;
  logic   out_free;
  logic   s1_take;

  assign out_free      = !pixel_out.valid || pixel_out.ready;
  assign s1_take       = s1_valid && out_free;
  assign line_in.ready = !s1_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (line_in.valid && line_in.ready) begin
      s1_valid <= 1'b1;
    end else if (s1_take) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (line_in.valid && line_in.ready) begin
      s1_action <= line_in.action;
      s1_x1     <= line_in.start_x;
      s1_y1     <= line_in.start_y;
      s1_x2     <= line_in.end_x;
      s1_y2     <= line_in.end_y;
    end
  end

  line_setup_t setup;

  bsl_setup u_setup (
    .x1    (s1_x1),
    .y1    (s1_y1),
    .x2    (s1_x2),
    .y2    (s1_y2),
    .style (line_style),
    .setup (setup)
  );

  // line state
  coord_t cur_x, cur_y, major_delta, minor_delta;
  err_t   error_term;
  rem_t   remaining;
  pat_t   pattern_index;
  logic   dir_x_neg, dir_y_neg, steep, active;

  coord_t cur_x_next, cur_y_next;
  err_t   error_term_next;
  rem_t   remaining_next;
  pat_t   pattern_index_next;
  logic   plot_next, last_next;
  logic   minor_step;
  logic   do_start, do_step;
  err_t   err_sum;

  assign do_start = s1_take && (s1_action == ACT_START);
  assign do_step  = s1_take && (s1_action == ACT_STEP) && active;

  always_comb begin
    pattern_index_next = (pattern_index >= PAT_MAX) ? '0 : pattern_index + pat_t'(1);
    case (line_style)
      STYLE_DOTTED: plot_next = (pattern_index_next == DOT_A) ||
                                (pattern_index_next == DOT_B);
      STYLE_DASHED: plot_next = pattern_index_next < DASH_ON_LEN;
      default:      plot_next = 1'b1;
    endcase
    last_next = remaining == rem_t'(1);

    minor_step = !error_term[ERR_BITS-1];
    err_sum    = error_term + signed'({1'b0, minor_delta, 1'b0});
    error_term_next = minor_step ? err_sum - signed'({1'b0, major_delta, 1'b0}) : err_sum;

    cur_x_next = cur_x;
    cur_y_next = cur_y;
    if (steep || minor_step) begin
      cur_y_next = dir_y_neg ? cur_y - coord_t'(1) : cur_y + coord_t'(1);
    end
    if (!steep || minor_step) begin
      cur_x_next = dir_x_neg ? cur_x - coord_t'(1) : cur_x + coord_t'(1);
    end
    remaining_next = remaining - rem_t'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x         <= '0;
      cur_y         <= '0;
      major_delta   <= '0;
      minor_delta   <= '0;
      error_term    <= '0;
      remaining     <= '0;
      pattern_index <= '0;
      dir_x_neg     <= 1'b0;
      dir_y_neg     <= 1'b0;
      steep         <= 1'b0;
      active        <= 1'b0;
    end else if (do_start) begin
      cur_x         <= setup.cur_x;
      cur_y         <= setup.cur_y;
      major_delta   <= setup.major_delta;
      minor_delta   <= setup.minor_delta;
      error_term    <= setup.error_term;
      remaining     <= setup.remaining;
      pattern_index <= '0;
      dir_x_neg     <= setup.dir_x_neg;
      dir_y_neg     <= setup.dir_y_neg;
      steep         <= setup.steep;
      active        <= setup.remaining != '0;
    end else if (do_step) begin
      cur_x         <= cur_x_next;
      cur_y         <= cur_y_next;
      error_term    <= error_term_next;
      remaining     <= remaining_next;
      pattern_index <= pattern_index_next;
      active        <= remaining_next != '0;
    end
  end

  // pixel register
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_out.valid <= 1'b0;
    end else if (do_step) begin
      pixel_out.valid <= 1'b1;
    end else if (pixel_out.ready) begin
      pixel_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_step) begin
      pixel_out.pixel_x <= cur_x;
      pixel_out.pixel_y <= cur_y;
      pixel_out.plot    <= plot_next;
      pixel_out.last    <= last_next;
    end
  end

  // checks
  a_active_count: assert property (@(posedge clk) disable iff (rst)
    active |-> remaining != '0)
    else $error("active line with no positions left");

  a_pat_range: assert property (@(posedge clk) disable iff (rst)
    pattern_index <= PAT_MAX)
    else $error("pattern index out of range");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    do_step && last_next |=> !active)
    else $error("line still active after last position");

  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> line_in.ready)
    else $error("input stalled with empty input register");

endmodule

`default_nettype wire

/* dv/bresenham_styled_line_rasterizer_tb.sv */
// Testbench for the styled Bresenham line rasterizer: drives line items and style
// writes, predicts each pixel item in a scoreboard class and compares it as a whole.
// Depends on bsl_pkg, bsl_if and the rasterizer RTL.

module bresenham_styled_line_rasterizer_tb import bsl_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int SEG_ITEMS    = 105;
  localparam int DRAIN_CYCLES = 4;

  typedef struct packed {
    logic   action;
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } line_item_t;

  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    logic   plot;
    logic   last;
  } pixel_t;

  class pixel_scoreboard;
    coord_t cur_x, cur_y, major_d, minor_d;
    err_t   err;
    rem_t   left;
    pat_t   pat;
    logic   x_neg, y_neg, steep, active;
    style_t style;
    pixel_t pixel_q[$];
    int     errors;
    int     mismatches;

    function new();
      cur_x = '0; cur_y = '0; major_d = '0; minor_d = '0;
      err = '0; left = '0; pat = '0;
      x_neg = 0; y_neg = 0; steep = 0; active = 0;
      style = STYLE_SIMPLE;
      errors = 0;
      mismatches = 0;
    endfunction

    function void set_style(style_t s);
      style = s;
    endfunction

    function coord_t walk(coord_t v, logic neg);
      return neg ? v - coord_t'(1) : v + coord_t'(1);
    endfunction

    // returns 1 when the item is a start or yields a pixel
    function bit note_item(line_item_t it);
      coord_t dx, dy;
      pixel_t px;
      int     e;
      if (it.action == ACT_START) begin
        dx = (it.end_x >= it.start_x) ? it.end_x - it.start_x : it.start_x - it.end_x;
        dy = (it.end_y >= it.start_y) ? it.end_y - it.start_y : it.start_y - it.end_y;
        x_neg   = it.end_x < it.start_x;
        y_neg   = it.end_y < it.start_y;
        steep   = dy > dx;
        major_d = steep ? dy : dx;
        minor_d = steep ? dx : dy;
        cur_x   = it.start_x;
        cur_y   = it.start_y;
        err     = err_t'(2 * int'(minor_d) - int'(major_d));
        pat     = '0;
        left    = rem_t'(major_d);
        if (style != STYLE_DOTTED && style != STYLE_DASHED) left = left + rem_t'(1);
        active  = left != '0;
        return 1;
      end
      if (!active) return 0;
      pat = (pat >= PAT_MAX) ? pat_t'(0) : pat + pat_t'(1);
      if (style == STYLE_DOTTED) px.plot = (pat == DOT_A) || (pat == DOT_B);
      else if (style == STYLE_DASHED) px.plot = pat < DASH_ON_LEN;
      else px.plot = 1'b1;
      px.last    = left == rem_t'(1);
      px.pixel_x = cur_x;
      px.pixel_y = cur_y;
      pixel_q.push_back(px);
      if (steep) cur_y = walk(cur_y, y_neg);
      else cur_x = walk(cur_x, x_neg);
      e = int'(err);
      if (e >= 0) begin
        if (steep) cur_x = walk(cur_x, x_neg);
        else cur_y = walk(cur_y, y_neg);
        e = e - 2 * int'(major_d);
      end
      e = e + 2 * int'(minor_d);
      err = err_t'(e);
      left = left - rem_t'(1);
      active = left != '0;
      return 1;
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      if (pixel_q.size() == 0) begin
        errors++;
        if (mismatches++ < 10)
          $display("unexpected pixel item x=%0d y=%0d plot=%0b last=%0b",
                   got.pixel_x, got.pixel_y, got.plot, got.last);
        return;
      end
      want = pixel_q.pop_front();
      if (got !== want) begin
        errors++;
        if (mismatches++ < 10)
          $display("mismatch exp x=%0d y=%0d p=%0b l=%0b got x=%0d y=%0d p=%0b l=%0b",
                   want.pixel_x, want.pixel_y, want.plot, want.last,
                   got.pixel_x, got.pixel_y, got.plot, got.last);
      end
    endfunction

    function int pending();
      return pixel_q.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  bsl_in_if  line_in();
  bsl_out_if pixel_out();
  bsl_cfg_if cfg();

  bresenham_styled_line_rasterizer DUT (
    .clk       (clk),
    .rst       (rst),
    .line_in   (line_in),
    .pixel_out (pixel_out),
    .cfg       (cfg)
  );

  pixel_scoreboard sb = new();
  int src_idle_pct;
  int sink_idle_pct;
  int item_count;
  int cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // pixel sink: check at the edge, then pick ready for the next cycle
  initial begin
    pixel_t got;
    pixel_out.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && pixel_out.valid === 1'b1 && pixel_out.ready === 1'b1) begin
        got.pixel_x = pixel_out.pixel_x;
        got.pixel_y = pixel_out.pixel_y;
        got.plot    = pixel_out.plot;
        got.last    = pixel_out.last;
        sb.check_pixel(got);
      end
      pixel_out.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  task automatic send_line_item(logic act, coord_t sx, coord_t sy, coord_t ex, coord_t ey);
    line_item_t it;
    it = '{action: act, start_x: sx, start_y: sy, end_x: ex, end_y: ey};
    while ($urandom_range(99) < src_idle_pct) begin
      line_in.valid <= 1'b0;
      @(posedge clk);
    end
    line_in.valid   <= 1'b1;
    line_in.action  <= act;
    line_in.start_x <= sx;
    line_in.start_y <= sy;
    line_in.end_x   <= ex;
    line_in.end_y   <= ey;
    do @(posedge clk); while (line_in.ready !== 1'b1);
    if (sb.note_item(it)) item_count++;
  endtask

  task automatic step_line(int n);
    repeat (n)
      send_line_item(ACT_STEP, coord_t'($urandom), coord_t'($urandom),
                     coord_t'($urandom), coord_t'($urandom));
  endtask

  task automatic wait_drained();
    line_in.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_style(style_t s);
    cfg.valid <= 1'b1;
    cfg.data  <= s;
    do @(posedge clk); while (cfg.ready !== 1'b1);
    cfg.valid <= 1'b0;
    sb.set_style(s);
  endtask

  // end point at distance d from s, mirrored when it would leave the coordinate range
  function automatic coord_t offset_coord(coord_t s, int d);
    int v;
    v = $urandom_range(1) ? int'(s) + d : int'(s) - d;
    if (v > 2047) v = int'(s) - d;
    if (v < 0) v = int'(s) + d;
    return coord_t'(v);
  endfunction

  task automatic random_line();
    int     kind, span, dx, dy, n, total;
    coord_t sx, sy;
    kind = $urandom_range(99);
    span = (kind < 80) ? 12 : (kind < 93) ? 40 : 2047;
    dx = $urandom_range(span);
    dy = $urandom_range(span);
    if ($urandom_range(9) == 0) dy = dx;
    sx = coord_t'($urandom);
    sy = coord_t'($urandom);
    send_line_item(ACT_START, sx, sy, offset_coord(sx, dx), offset_coord(sy, dy));
    total = int'(sb.left);
    if (span == 2047) n = $urandom_range(20);
    else if ($urandom_range(9) == 0) n = $urandom_range(total);
    else n = total + $urandom_range(2);
    step_line(n);
  endtask

  style_t seg_style [12] = '{STYLE_DOTTED, STYLE_DASHED, 2'd3, STYLE_SIMPLE,
                             STYLE_DASHED, STYLE_SIMPLE, STYLE_DOTTED, 2'd3,
                             2'd3, STYLE_DOTTED, STYLE_SIMPLE, STYLE_DASHED};

  initial begin
    int seg_start;
    cycles          = 0;
    item_count      = 0;
    src_idle_pct    = 35;
    sink_idle_pct   = 54;
    rst             <= 1'b1;
    line_in.valid   <= 1'b0;
    line_in.action  <= ACT_STEP;
    line_in.start_x <= '0;
    line_in.start_y <= '0;
    line_in.end_x   <= '0;
    line_in.end_y   <= '0;
    cfg.valid       <= 1'b0;
    cfg.data        <= STYLE_SIMPLE;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: step while idle, full-range diagonal, restart mid-line,
    // single point, steep line
    step_line(1);
    send_line_item(ACT_START, 11'd0, 11'd0, 11'd2047, 11'd2047);
    step_line(3);
    send_line_item(ACT_START, 11'd2047, 11'd0, 11'd0, 11'd2047);
    step_line(2);
    send_line_item(ACT_START, 11'd5, 11'd5, 11'd5, 11'd5);
    step_line(2);
    send_line_item(ACT_START, 11'd10, 11'd10, 11'd12, 11'd16);
    step_line(8);

    for (int seg = 0; seg < 12; seg++) begin
      if (seg == 4) begin
        src_idle_pct  = 54;
        sink_idle_pct = 35;
      end else if (seg == 8) begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end
      wait_drained();
      write_style(seg_style[seg]);
      // finish the line left open before the style change
      step_line(14);
      // start, restart with equal endpoints: one position in simple style, none when styled
      send_line_item(ACT_START, coord_t'($urandom), 11'd300, 11'd0, 11'd300);
      send_line_item(ACT_START, 11'd700, 11'd700, 11'd700, 11'd700);
      step_line(2);
      seg_start = item_count;
      while (item_count - seg_start < SEG_ITEMS) begin
        if ($urandom_range(19) == 0) step_line($urandom_range(1, 3));
        else random_line();
      end
      send_line_item(ACT_START, 11'd1000, 11'd1000, 11'd1014, 11'd1006);
      step_line(6);
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
